// File: hw/rtl/smpd_pkg.sv
// shared types and constants for the steering magnet pid drive
`default_nettype none
package smpd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_LEFT     = 3'd0;
    localparam logic [2:0] CFG_WIDTH    = 3'd1;
    localparam logic [2:0] CFG_DEADBAND = 3'd2;
    localparam logic [2:0] CFG_GAIN_P   = 3'd3;
    localparam logic [2:0] CFG_GAIN_I   = 3'd4;
    localparam logic [2:0] CFG_GAIN_D   = 3'd5;
    localparam logic [2:0] CFG_DUTY_MIN = 3'd6;
    localparam logic [2:0] CFG_DUTY_MAX = 3'd7;

    // register reset values
    localparam logic [15:0] RST_LEFT     = 16'hFFF9;
    localparam logic [15:0] RST_WIDTH    = 16'd1677;
    localparam logic [14:0] RST_DEADBAND = 15'd614;
    localparam logic [15:0] RST_GAIN_P   = 16'd256;
    localparam logic [15:0] RST_GAIN_I   = 16'd13;
    localparam logic [15:0] RST_GAIN_D   = 16'd2048;
    localparam logic [7:0]  RST_DUTY_MIN = 8'd40;
    localparam logic [7:0]  RST_DUTY_MAX = 8'd255;
    // left extreme plus half the reset width
    localparam logic [15:0] RST_TARGET   = 16'd831;

    // angle mapping constants
    localparam logic [16:0] ANGLE_OFFSET = 17'd4500;
    localparam logic [32:0] ROUND_HALF   = 33'd9000;
    localparam logic [32:0] ROUND_FLOOR  = 33'd8999;
    // divide by 18000: shift out 4 bits (divide by 16), then multiply by 2^40/1125 rounded up
    localparam logic [29:0] RECIP_1125   = 30'd977343670;

    // division width and step count
    localparam int DVD_W = 58;
    localparam logic [5:0] DIV_LAST_STEP = 6'(DVD_W - 1);

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_BRAKE,
        OP_SETTLE,
        OP_CMUL,
        OP_CPREP,
        OP_CRECIP,
        OP_DIV,
        OP_CFIN,
        OP_TSUM,
        OP_MP,
        OP_MI,
        OP_MD,
        OP_MACC,
        OP_MLO,
        OP_MHI,
        OP_MCOMB
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   tfin;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic brake;
        logic outside;
        logic div_last;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hw/rtl/smpd_if.sv
// handshake channels for items and results
`default_nettype none
interface smpd_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [14:0] angle;
    logic               brake;
    logic signed [15:0] magnet_sample;

    modport source (output valid, operation, angle, brake, magnet_sample, input ready);
    modport sink   (input valid, operation, angle, brake, magnet_sample, output ready);
endinterface

interface smpd_result_if;
    logic               valid;
    logic               ready;
    logic               extend_pin;
    logic               reduce_pin;
    logic [7:0]         duty;
    logic signed [15:0] target_magnet;

    modport source (output valid, extend_pin, reduce_pin, duty, target_magnet, input ready);
    modport sink   (input valid, extend_pin, reduce_pin, duty, target_magnet, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/smpd_datapath.sv
// registers, shared multiplier and serial divider of the pid drive
`default_nettype none
module smpd_datapath
    import smpd_pkg::*;
#(
    parameter int SUM_WIDTH    = 20,
    parameter int SETTLE_TICKS = 3
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_operation,
    input  wire logic signed [14:0] in_angle,
    input  wire logic               in_brake,
    input  wire logic signed [15:0] in_magnet_sample,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    output logic                    res_extend,
    output logic                    res_reduce,
    output logic [7:0]              res_duty,
    output logic signed [15:0]      res_target
);

    localparam logic [2:0] SettleLim = 3'(SETTLE_TICKS);
    localparam logic [SUM_WIDTH-1:0] SumMax = '1;

    // configuration
    logic [15:0] left_reg, width_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic [14:0] deadband_reg;
    logic [7:0]  duty_min_reg, duty_max_reg;

    // control state
    logic [15:0]          target_reg;
    logic [SUM_WIDTH-1:0] sum_reg;
    logic [15:0]          prev_reg;
    logic [2:0]           settle_reg;
    logic                 extend_reg, reduce_reg;
    logic [7:0]           duty_reg;

    // working registers
    logic        tick_reg, brake_reg, neg_reg, asign_reg, qneg_reg;
    logic [14:0] absa_reg;
    logic [15:0] mag_reg, diff_reg;
    logic [47:0] prod_reg;
    logic [49:0] acc_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [23:0] rem_reg, dsr_reg;
    logic [5:0]  cnt_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg     <= RST_LEFT;
            width_reg    <= RST_WIDTH;
            deadband_reg <= RST_DEADBAND;
            gain_p_reg   <= RST_GAIN_P;
            gain_i_reg   <= RST_GAIN_I;
            gain_d_reg   <= RST_GAIN_D;
            duty_min_reg <= RST_DUTY_MIN;
            duty_max_reg <= RST_DUTY_MAX;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LEFT:     left_reg     <= cfg_data;
                CFG_WIDTH:    width_reg    <= cfg_data;
                CFG_DEADBAND: deadband_reg <= cfg_data[14:0];
                CFG_GAIN_P:   gain_p_reg   <= cfg_data;
                CFG_GAIN_I:   gain_i_reg   <= cfg_data;
                CFG_GAIN_D:   gain_d_reg   <= cfg_data;
                CFG_DUTY_MIN: duty_min_reg <= cfg_data[7:0];
                CFG_DUTY_MAX: duty_max_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // input decode: shifted angle and signed error
    logic [16:0] ang_sh;
    logic [16:0] err;
    assign ang_sh = 17'(in_angle) + ANGLE_OFFSET;
    assign err    = {target_reg[15], target_reg} - {in_magnet_sample[15], in_magnet_sample};

    // shared multiplier operand select
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [7:0]  range;
    logic [47:0] mul_p;
    assign range = duty_max_reg - duty_min_reg;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_CMUL: begin mul_a = 32'(absa_reg);        mul_b = width_reg;   end
            OP_MP:   begin mul_a = 32'(mag_reg);         mul_b = gain_p_reg;  end
            OP_MI:   begin mul_a = 32'(sum_reg);         mul_b = gain_i_reg;  end
            OP_MD:   begin mul_a = 32'(diff_reg);        mul_b = gain_d_reg;  end
            OP_MLO:  begin mul_a = acc_reg[31:0];        mul_b = 16'(range);  end
            OP_MHI:  begin mul_a = 32'(acc_reg[49:32]);  mul_b = 16'(range);  end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // angle quotient by reciprocal multiply, dividend below 2^33
    logic [58:0] recip_p;
    assign recip_p = 59'(dvd_reg[32:4]) * 59'(RECIP_1125);

    // one restoring division step
    logic [24:0] rem_t, rem_d;
    logic        qbit;
    assign rem_t = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_d = rem_t - {1'b0, dsr_reg};
    assign qbit  = !rem_d[24];

    // integral term
    logic [SUM_WIDTH:0] sum_add;
    assign sum_add = {1'b0, sum_reg} + (SUM_WIDTH + 1)'(mag_reg);

    // angle numerator prep
    logic [32:0] two_p;
    assign two_p = {prod_reg[31:0], 1'b0};

    // command result: saturated target
    logic [22:0] q_s, t_sum;
    logic [15:0] t_sat;
    assign q_s   = qneg_reg ? (23'd0 - 23'(dvd_reg[20:0])) : 23'(dvd_reg[20:0]);
    assign t_sum = {{7{left_reg[15]}}, left_reg} + q_s;
    always_comb
    begin
        if (!t_sum[22] && (t_sum[21:15] != 7'd0))
            t_sat = 16'h7FFF;
        else if (t_sum[22] && (t_sum[21:15] != 7'h7F))
            t_sat = 16'h8000;
        else
            t_sat = t_sum[15:0];
    end

    // tick result: scaled and clamped duty
    logic [7:0] duty_calc;
    always_comb
    begin
        if (width_reg == 16'd0)
            duty_calc = (duty_max_reg >= duty_min_reg) ? duty_max_reg : duty_min_reg;
        else if (duty_max_reg < duty_min_reg)
            duty_calc = duty_min_reg;
        else if (dvd_reg > DVD_W'(range))
            duty_calc = duty_max_reg;
        else
            duty_calc = duty_min_reg + dvd_reg[7:0];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                tick_reg  <= in_operation;
                brake_reg <= in_brake;
                asign_reg <= ang_sh[16];
                absa_reg  <= ang_sh[16] ? 15'(17'd0 - ang_sh) : ang_sh[14:0];
                neg_reg   <= err[16];
                mag_reg   <= err[16] ? 16'(17'd0 - err) : err[15:0];
            end
            OP_CPREP:
            begin
                if (!asign_reg)
                begin
                    dvd_reg  <= DVD_W'(two_p + ROUND_HALF);
                    qneg_reg <= 1'b0;
                end
                else if (two_p > ROUND_HALF)
                begin
                    dvd_reg  <= DVD_W'(two_p + ROUND_FLOOR);
                    qneg_reg <= 1'b1;
                end
                else
                begin
                    dvd_reg  <= DVD_W'(ROUND_HALF - two_p);
                    qneg_reg <= 1'b0;
                end
            end
            OP_CRECIP:
                dvd_reg <= DVD_W'(recip_p[58:40]);
            OP_DIV:
            begin
                rem_reg <= qbit ? rem_d[23:0] : rem_t[23:0];
                dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
                cnt_reg <= cnt_reg - 6'd1;
            end
            OP_TSUM:
            begin
                diff_reg <= (mag_reg >= prev_reg) ? (mag_reg - prev_reg) : (prev_reg - mag_reg);
                acc_reg  <= '0;
            end
            OP_MI, OP_MD, OP_MACC:
                acc_reg <= acc_reg + 50'(prod_reg);
            OP_MHI:
                dvd_reg <= DVD_W'(prod_reg);
            OP_MCOMB:
            begin
                dvd_reg <= dvd_reg + {prod_reg[25:0], 32'd0};
                rem_reg <= '0;
                dsr_reg <= {width_reg, 8'd0};
                cnt_reg <= DIV_LAST_STEP;
            end
            default: ;
        endcase
        prod_reg <= mul_p;
        if (cmd.out_load)
        begin
            res_extend <= extend_reg;
            res_reduce <= reduce_reg;
            res_duty   <= duty_reg;
            res_target <= target_reg;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= RST_TARGET;
            sum_reg    <= '0;
            prev_reg   <= '0;
            settle_reg <= '0;
            extend_reg <= 1'b1;
            reduce_reg <= 1'b1;
            duty_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_BRAKE:
                begin
                    extend_reg <= 1'b1;
                    reduce_reg <= 1'b1;
                    sum_reg    <= '0;
                end
                OP_CFIN:
                begin
                    target_reg <= t_sat;
                    sum_reg    <= '0;
                end
                OP_SETTLE:
                begin
                    duty_reg   <= '0;
                    extend_reg <= 1'b1;
                    reduce_reg <= 1'b1;
                    if ((settle_reg > SettleLim) || (settle_reg == 3'd7))
                    begin
                        sum_reg    <= '0;
                        settle_reg <= '0;
                    end
                    else
                        settle_reg <= settle_reg + 3'd1;
                end
                OP_TSUM:
                begin
                    extend_reg <= neg_reg;
                    reduce_reg <= !neg_reg;
                    prev_reg   <= mag_reg;
                    sum_reg    <= sum_add[SUM_WIDTH] ? SumMax : sum_add[SUM_WIDTH-1:0];
                end
                default: ;
            endcase
            if (cmd.tfin)
                duty_reg <= duty_calc;
        end
    end

    assign status.is_tick  = tick_reg;
    assign status.brake    = brake_reg;
    assign status.outside  = mag_reg > {1'b0, deadband_reg};
    assign status.div_last = cnt_reg == 6'd0;

endmodule
`default_nettype wire

// File: hw/rtl/smpd_ctrl.sv
// sequencing state machine and result handshake of the pid drive
`default_nettype none
module smpd_ctrl
    import smpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [14:0] {
        ST_IDLE   = 15'h0001,
        ST_EVAL   = 15'h0002,
        ST_CPREP  = 15'h0004,
        ST_CRECIP = 15'h0008,
        ST_DIV    = 15'h0010,
        ST_CFIN   = 15'h0020,
        ST_MP     = 15'h0040,
        ST_MI     = 15'h0080,
        ST_MD     = 15'h0100,
        ST_MACC   = 15'h0200,
        ST_MLO    = 15'h0400,
        ST_MHI    = 15'h0800,
        ST_MCOMB  = 15'h1000,
        ST_TFIN   = 15'h2000,
        ST_DONE   = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and datapath command
    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.tfin     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (!status.is_tick && status.brake)
                begin
                    cmd.op     = OP_BRAKE;
                    state_next = ST_DONE;
                end
                else if (!status.is_tick)
                begin
                    cmd.op     = OP_CMUL;
                    state_next = ST_CPREP;
                end
                else if (status.outside)
                begin
                    cmd.op     = OP_TSUM;
                    state_next = ST_MP;
                end
                else
                begin
                    cmd.op     = OP_SETTLE;
                    state_next = ST_DONE;
                end
            end
            ST_CPREP:
            begin
                cmd.op     = OP_CPREP;
                state_next = ST_CRECIP;
            end
            ST_CRECIP:
            begin
                cmd.op     = OP_CRECIP;
                state_next = ST_CFIN;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_last)
                    state_next = ST_TFIN;
            end
            ST_CFIN:
            begin
                cmd.op     = OP_CFIN;
                state_next = ST_DONE;
            end
            ST_MP:
            begin
                cmd.op     = OP_MP;
                state_next = ST_MI;
            end
            ST_MI:
            begin
                cmd.op     = OP_MI;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.op     = OP_MD;
                state_next = ST_MACC;
            end
            ST_MACC:
            begin
                cmd.op     = OP_MACC;
                state_next = ST_MLO;
            end
            ST_MLO:
            begin
                cmd.op     = OP_MLO;
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                cmd.op     = OP_MHI;
                state_next = ST_MCOMB;
            end
            ST_MCOMB:
            begin
                cmd.op     = OP_MCOMB;
                state_next = ST_DIV;
            end
            ST_TFIN:
            begin
                cmd.tfin   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // result beat holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: hw/rtl/steering_magnet_pid_drive_core.sv
// top level of the steering magnet pid drive
//
//  port     dir   role
//  item     sink  steering command or control tick with magnet sample
//  result   src   bridge direction levels, duty and current target
//  cfg_*    in    register writes, index 0..7
//
// one item at a time: a brake command or a tick inside the deadband goes straight to done,
// a steering command uses a reciprocal multiply for the constant divide, and a tick
// outside the deadband runs the pid terms through the shared 32x16 multiplier and the
// 58-step serial divider
// a finished beat waits in the result register while the next item is accepted
// rst_n resets control state and loads the register reset values
`default_nettype none
module steering_magnet_pid_drive_core
    import smpd_pkg::*;
#(
    parameter int SUM_WIDTH    = 20,
    parameter int SETTLE_TICKS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    smpd_item_if.sink        item,
    smpd_result_if.source    result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing
    smpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and state
    smpd_datapath #(
        .SUM_WIDTH    (SUM_WIDTH),
        .SETTLE_TICKS (SETTLE_TICKS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_operation     (item.operation),
        .in_angle         (item.angle),
        .in_brake         (item.brake),
        .in_magnet_sample (item.magnet_sample),
        .cmd              (cmd),
        .status           (status),
        .res_extend       (result.extend_pin),
        .res_reduce       (result.reduce_pin),
        .res_duty         (result.duty),
        .res_target       (result.target_magnet)
    );

endmodule
`default_nettype wire
